/* sv/gmcp_pkg.sv */
// Package for the grid max coin path unit: field widths, register indexes,
// controller states and the command/status bundles between control and datapath.
// No dependencies.
package gmcp_pkg;

   localparam int RC_W      = 5;
   localparam int CFG_W     = 6;
   localparam int COINS_W   = 4;
   localparam int TOTAL_W   = 10;
   localparam int SCORE_W   = 11;
   localparam int CSR_IDX_W = 2;
   localparam int PATH_W    = 2 * RC_W;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_ROWS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_COLS = 2'd1;

   typedef logic signed [SCORE_W-1:0] score_type;

   localparam score_type NO_SCORE = -11'sd1;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_RECORD,
      ST_TRACE_UP,
      ST_TRACE_LEFT,
      ST_TRACE_STEP,
      ST_EMIT_RD,
      ST_EMIT_OUT
   } gmcp_state_type;

   typedef struct packed {
      logic load;
      logic csr_wr;
      logic rec;
      logic rd_up;
      logic rd_left;
      logic step;
      logic emit_rd;
      logic emit_next;
   } gmcp_cmd_type;

   typedef struct packed {
      logic cell_last;
      logic cell_reach;
      logic at_start;
      logic emit_last;
   } gmcp_sts_type;

endpackage

/* sv/gmcp_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module gmcp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/gmcp_dp.sv */
// Datapath of the grid max coin path unit: config registers, load pointer, cell
// scoring, traceback position and counters, score table and path store.
// Depends on gmcp_pkg and gmcp_ram.
module gmcp_dp
   import gmcp_pkg::*;
#(
   parameter int MAX_ROWS = 32,
   parameter int MAX_COLS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  gmcp_cmd_type          cmd,
   output gmcp_sts_type          sts,
   input  logic                  cell_blocked,
   input  logic [COINS_W-1:0]    cell_coins,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]      csr_data,
   output logic [RC_W-1:0]       path_row,
   output logic [RC_W-1:0]       path_col,
   output logic [TOTAL_W-1:0]    total,
   output logic                  reachable
);

   localparam int TBL_DEPTH  = MAX_ROWS * MAX_COLS;
   localparam int TBL_AW     = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
   localparam int PATH_DEPTH = MAX_ROWS + MAX_COLS - 1;
   localparam int PAW        = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;

   function automatic logic [TBL_AW-1:0] cell_addr(logic [RC_W-1:0] r, logic [RC_W-1:0] c);
      logic [2*RC_W:0] full;
      full = (2*RC_W+1)'(r) * (2*RC_W+1)'(MAX_COLS) + (2*RC_W+1)'(c);
      return TBL_AW'(full);
   endfunction

   logic [CFG_W-1:0]   rows_cfg_ff, rows_cfg_in;
   logic [CFG_W-1:0]   cols_cfg_ff, cols_cfg_in;
   logic [RC_W-1:0]    ld_r_ff, ld_r_in;
   logic [RC_W-1:0]    ld_c_ff, ld_c_in;
   score_type          prev_ff;
   score_type          up_ff;
   logic [TOTAL_W-1:0] total_ff;
   logic               reach_ff;
   logic [RC_W-1:0]    tr_r_ff, tr_r_in;
   logic [RC_W-1:0]    tr_c_ff, tr_c_in;
   logic [PAW-1:0]     k_ff, k_in;
   logic [PAW-1:0]     i_ff, i_in;
   logic [PAW-1:0]     n1_ff;

   logic [CFG_W-1:0]   eff_rows, eff_cols;
   logic               last_cell;
   logic [RC_W-1:0]    nxt_r, nxt_c;
   score_type          tbl_rdata, up_nb, left_nb, best, cell_score, left_tr;
   logic [PAW-1:0]     n1;
   logic [TBL_AW-1:0]  tbl_rd_addr;
   logic [PATH_W-1:0]  path_rdata;

   always_comb begin
      if (rows_cfg_ff == '0) begin
         eff_rows = CFG_W'(1);
      end else if (rows_cfg_ff > CFG_W'(MAX_ROWS)) begin
         eff_rows = CFG_W'(MAX_ROWS);
      end else begin
         eff_rows = rows_cfg_ff;
      end
      if (cols_cfg_ff == '0) begin
         eff_cols = CFG_W'(1);
      end else if (cols_cfg_ff > CFG_W'(MAX_COLS)) begin
         eff_cols = CFG_W'(MAX_COLS);
      end else begin
         eff_cols = cols_cfg_ff;
      end

      last_cell = (CFG_W'(ld_r_ff) + CFG_W'(1) >= eff_rows) &&
                  (CFG_W'(ld_c_ff) + CFG_W'(1) >= eff_cols);
      if (CFG_W'(ld_c_ff) + CFG_W'(1) >= eff_cols) begin
         nxt_c = '0;
         nxt_r = ld_r_ff + RC_W'(1);
      end else begin
         nxt_c = ld_c_ff + RC_W'(1);
         nxt_r = ld_r_ff;
      end
      n1 = PAW'(7'(eff_rows) + 7'(eff_cols) - 7'd2);

      if (ld_r_ff == '0) begin
         up_nb = NO_SCORE;
      end else if (eff_cols == CFG_W'(1)) begin
         up_nb = prev_ff;
      end else begin
         up_nb = tbl_rdata;
      end
      left_nb = (ld_c_ff != '0) ? prev_ff : NO_SCORE;
      best    = (up_nb > left_nb) ? up_nb : left_nb;

      if (cell_blocked) begin
         cell_score = NO_SCORE;
      end else if (ld_r_ff == '0 && ld_c_ff == '0) begin
         cell_score = SCORE_W'(cell_coins);
      end else if (best < 0) begin
         cell_score = NO_SCORE;
      end else begin
         cell_score = best + SCORE_W'(cell_coins);
      end

      left_tr = (tr_c_ff != '0) ? tbl_rdata : NO_SCORE;

      if (cmd.load) begin
         tbl_rd_addr = cell_addr(nxt_r - RC_W'(1), nxt_c);
      end else if (cmd.rd_up) begin
         tbl_rd_addr = cell_addr(tr_r_ff - RC_W'(1), tr_c_ff);
      end else begin
         tbl_rd_addr = cell_addr(tr_r_ff, tr_c_ff - RC_W'(1));
      end
   end

   always_comb begin
      rows_cfg_in = rows_cfg_ff;
      cols_cfg_in = cols_cfg_ff;
      ld_r_in     = ld_r_ff;
      ld_c_in     = ld_c_ff;
      tr_r_in     = tr_r_ff;
      tr_c_in     = tr_c_ff;
      k_in        = k_ff;
      i_in        = i_ff;
      if (cmd.csr_wr) begin
         if (csr_index == CSR_NUM_ROWS) begin
            rows_cfg_in = csr_data;
            ld_r_in     = '0;
            ld_c_in     = '0;
         end else if (csr_index == CSR_NUM_COLS) begin
            cols_cfg_in = csr_data;
            ld_r_in     = '0;
            ld_c_in     = '0;
         end
      end
      if (cmd.load) begin
         if (last_cell) begin
            ld_r_in = '0;
            ld_c_in = '0;
            tr_r_in = RC_W'(eff_rows - CFG_W'(1));
            tr_c_in = RC_W'(eff_cols - CFG_W'(1));
            k_in    = n1;
            i_in    = '0;
         end else begin
            ld_r_in = nxt_r;
            ld_c_in = nxt_c;
         end
      end
      if (cmd.step) begin
         if (up_ff > left_tr) begin
            tr_r_in = tr_r_ff - RC_W'(1);
         end else begin
            tr_c_in = tr_c_ff - RC_W'(1);
         end
         k_in = k_ff - PAW'(1);
      end
      if (cmd.emit_next) begin
         i_in = i_ff + PAW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_cfg_ff <= CFG_W'(32);
         cols_cfg_ff <= CFG_W'(32);
         ld_r_ff     <= '0;
         ld_c_ff     <= '0;
         tr_r_ff     <= '0;
         tr_c_ff     <= '0;
         k_ff        <= '0;
         i_ff        <= '0;
         n1_ff       <= '0;
         reach_ff    <= 1'b0;
      end else begin
         rows_cfg_ff <= rows_cfg_in;
         cols_cfg_ff <= cols_cfg_in;
         ld_r_ff     <= ld_r_in;
         ld_c_ff     <= ld_c_in;
         tr_r_ff     <= tr_r_in;
         tr_c_ff     <= tr_c_in;
         k_ff        <= k_in;
         i_ff        <= i_in;
         if (cmd.load && last_cell) begin
            n1_ff    <= n1;
            reach_ff <= !cell_score[SCORE_W-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         prev_ff <= cell_score;
         if (last_cell) begin
            total_ff <= TOTAL_W'(cell_score);
         end
      end
      if (cmd.rd_left) begin
         up_ff <= (tr_r_ff != '0) ? tbl_rdata : NO_SCORE;
      end
   end

   gmcp_ram #(
      .WIDTH (SCORE_W),
      .DEPTH (TBL_DEPTH)
   ) u_score_ram (
      .clock   (clock),
      .wr_en   (cmd.load),
      .wr_addr (cell_addr(ld_r_ff, ld_c_ff)),
      .wr_data (cell_score),
      .rd_en   (cmd.load | cmd.rd_up | cmd.rd_left),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rdata)
   );

   gmcp_ram #(
      .WIDTH (PATH_W),
      .DEPTH (PATH_DEPTH)
   ) u_path_ram (
      .clock   (clock),
      .wr_en   (cmd.rec),
      .wr_addr (k_ff),
      .wr_data ({tr_r_ff, tr_c_ff}),
      .rd_en   (cmd.emit_rd),
      .rd_addr (i_ff),
      .rd_data (path_rdata)
   );

   assign sts.cell_last  = last_cell;
   assign sts.cell_reach = !cell_score[SCORE_W-1];
   assign sts.at_start   = (tr_r_ff == '0) && (tr_c_ff == '0);
   assign sts.emit_last  = !reach_ff || (i_ff == n1_ff);

   assign path_row  = reach_ff ? path_rdata[PATH_W-1:RC_W] : '0;
   assign path_col  = reach_ff ? path_rdata[RC_W-1:0] : '0;
   assign total     = reach_ff ? total_ff : '0;
   assign reachable = reach_ff;

endmodule

/* sv/gmcp_ctrl.sv */
// Controller of the grid max coin path unit: sequences load, traceback and
// result beats, and drives the handshakes. Depends on gmcp_pkg.
module gmcp_ctrl
   import gmcp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic         csr_valid,
   output logic         csr_ready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output gmcp_cmd_type cmd,
   input  gmcp_sts_type sts
);

   gmcp_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      csr_ready  = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            csr_ready  = 1'b1;
            req_tready = !csr_valid;
            cmd.csr_wr = csr_valid;
            cmd.load   = req_tvalid && !csr_valid;
            if (cmd.load && sts.cell_last) begin
               state_in = sts.cell_reach ? ST_RECORD : ST_EMIT_OUT;
            end
         end
         ST_RECORD: begin
            cmd.rec  = 1'b1;
            state_in = sts.at_start ? ST_EMIT_RD : ST_TRACE_UP;
         end
         ST_TRACE_UP: begin
            cmd.rd_up = 1'b1;
            state_in  = ST_TRACE_LEFT;
         end
         ST_TRACE_LEFT: begin
            cmd.rd_left = 1'b1;
            state_in    = ST_TRACE_STEP;
         end
         ST_TRACE_STEP: begin
            cmd.step = 1'b1;
            state_in = ST_RECORD;
         end
         ST_EMIT_RD: begin
            cmd.emit_rd = 1'b1;
            state_in    = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (sts.emit_last) begin
                  state_in = ST_LOAD;
               end else begin
                  cmd.emit_next = 1'b1;
                  state_in      = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

endmodule

/* sv/grid_max_coin_path_unit.sv */
// Top level of the grid max coin path unit: best coin path through a grid,
// moving right or down, with traceback. Depends on gmcp_pkg, gmcp_ctrl, gmcp_dp.
//
//   channel | dir | beat carries
//   req_    | in  | one grid cell, row-major order
//   rsp_    | out | one path cell, start first, goal last (tlast on goal)
//   csr_    | in  | register write: 0 = num_rows, 1 = num_cols
//
// Cell beats are taken in ST_LOAD while no csr_ write is pending; the score table is read one cell ahead.
// After the last cell: each traceback step runs through the record, upper read, left read and step
// states (one table read port serves the upper and left reads), then each result beat is read
// out of the path store and offered on rsp_. An unreachable goal gives one beat directly.
// Reset leaves a 32 by 32 grid; a stalled rsp_ beat holds the block.
module grid_max_coin_path_unit
   import gmcp_pkg::*;
#(
   parameter int MAX_ROWS = 32,
   parameter int MAX_COLS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [3:0] coins
   input  logic                 req_tuser,   // [0] blocked
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [23:0]          rsp_tdata,   // [4:0] path_row, [9:5] path_col, [19:10] total
   output logic                 rsp_tuser,   // [0] reachable
   output logic                 rsp_tlast,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data
);

   gmcp_cmd_type       cmd;
   gmcp_sts_type       sts;
   logic [RC_W-1:0]    path_row, path_col;
   logic [TOTAL_W-1:0] total;
   logic               reachable;

   gmcp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   gmcp_dp #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .cell_blocked (req_tuser),
      .cell_coins   (req_tdata[COINS_W-1:0]),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .path_row     (path_row),
      .path_col     (path_col),
      .total        (total),
      .reachable    (reachable)
   );

   assign rsp_tdata = {4'b0, total, path_col, path_row};
   assign rsp_tuser = reachable;
   assign rsp_tlast = sts.emit_last;

endmodule

/* bench/grid_max_coin_path_unit_tb.sv */
// Self-checking bench for grid_max_coin_path_unit: streams grid cells, predicts the best
// coin path per grid and compares every rsp beat. Depends on gmcp_pkg and the unit RTL.
module grid_max_coin_path_unit_tb;
   import gmcp_pkg::*;

   localparam int TABLE_COLS    = 32;
   localparam int TABLE_DEPTH   = 1024;
   localparam int GRID_MAX      = 32;
   localparam int STALL_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES  = 24;
   localparam int RANDOM_CELLS  = 170;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   typedef struct {
      logic [RC_W-1:0]    row;
      logic [RC_W-1:0]    col;
      logic [TOTAL_W-1:0] total;
      logic               reach;
      logic               last;
   } path_beat_type;

   class coin_path_tracker;
      score_type        best[TABLE_DEPTH];
      logic [RC_W-1:0]  next_row;
      logic [RC_W-1:0]  next_col;
      logic [CFG_W-1:0] rows_reg;
      logic [CFG_W-1:0] cols_reg;
      path_beat_type    due[$];
      int unsigned      errors;

      function new();
         foreach (best[i]) best[i] = '0;
         next_row = '0;
         next_col = '0;
         rows_reg = 6'd32;
         cols_reg = 6'd32;
         errors   = 0;
      endfunction

      function int span(logic [CFG_W-1:0] v);
         if (v == 0) return 1;
         if (v > GRID_MAX) return GRID_MAX;
         return int'(v);
      endfunction

      function int score_at(int r, int c);
         return int'(best[(r * TABLE_COLS + c) % TABLE_DEPTH]);
      endfunction

      function void queue_beat(path_beat_type b);
         due = {due, b};
      endfunction

      function void take_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
         case (idx)
            CSR_NUM_ROWS: rows_reg = val;
            CSR_NUM_COLS: cols_reg = val;
            default: return;
         endcase
         next_row = '0;
         next_col = '0;
      endfunction

      function void note_cell(logic blk, logic [COINS_W-1:0] coins);
         int rows, cols, r, c, up, left, score, total;
         logic [PATH_W-1:0] trail[$];
         path_beat_type beat;
         rows = span(rows_reg);
         cols = span(cols_reg);
         r = next_row;
         c = next_col;
         if (blk) begin
            score = -1;
         end else if (r == 0 && c == 0) begin
            score = coins;
         end else begin
            up   = (r > 0) ? score_at(r - 1, c) : -1;
            left = (c > 0) ? score_at(r, c - 1) : -1;
            if (up < 0 && left < 0) score = -1;
            else score = ((up > left) ? up : left) + coins;
         end
         best[(r * TABLE_COLS + c) % TABLE_DEPTH] = score_type'(score);
         if (!(r + 1 >= rows && c + 1 >= cols)) begin
            c++;
            if (c >= cols) begin
               c = 0;
               r++;
            end
            next_row = r[RC_W-1:0];
            next_col = c[RC_W-1:0];
            return;
         end
         next_row = '0;
         next_col = '0;
         total = score_at(rows - 1, cols - 1);
         if (total < 0) begin
            beat.row   = '0;
            beat.col   = '0;
            beat.total = '0;
            beat.reach = 1'b0;
            beat.last  = 1'b1;
            queue_beat(beat);
            return;
         end
         r = rows - 1;
         c = cols - 1;
         trail.push_front({r[RC_W-1:0], c[RC_W-1:0]});
         while (r != 0 || c != 0) begin
            up   = (r > 0) ? score_at(r - 1, c) : -1;
            left = (c > 0) ? score_at(r, c - 1) : -1;
            if (up > left) r--;
            else c--;
            trail.push_front({r[RC_W-1:0], c[RC_W-1:0]});
         end
         foreach (trail[i]) begin
            beat.row   = trail[i][PATH_W-1:RC_W];
            beat.col   = trail[i][RC_W-1:0];
            beat.total = total[TOTAL_W-1:0];
            beat.reach = 1'b1;
            beat.last  = (i == trail.size() - 1);
            queue_beat(beat);
         end
      endfunction

      function void check_beat(logic [23:0] data, logic user, logic last);
         path_beat_type want;
         if (due.size() == 0) begin
            $error("rsp beat with no path cell due: tdata %h tuser %b tlast %b",
                   data, user, last);
            errors++;
            return;
         end
         want = due.pop_front();
         if (data[RC_W-1:0] !== want.row) begin
            $error("path_row: expected %0d, got %0d", want.row, data[RC_W-1:0]);
            errors++;
         end
         if (data[PATH_W-1:RC_W] !== want.col) begin
            $error("path_col: expected %0d, got %0d", want.col, data[PATH_W-1:RC_W]);
            errors++;
         end
         if (data[PATH_W+TOTAL_W-1:PATH_W] !== want.total) begin
            $error("total: expected %0d, got %0d", want.total,
                   data[PATH_W+TOTAL_W-1:PATH_W]);
            errors++;
         end
         if (data[23:PATH_W+TOTAL_W] !== '0) begin
            $error("tdata pad: expected 0, got %h", data[23:PATH_W+TOTAL_W]);
            errors++;
         end
         if (user !== want.reach) begin
            $error("reachable: expected %b, got %b", want.reach, user);
            errors++;
         end
         if (last !== want.last) begin
            $error("last: expected %b, got %b", want.last, last);
            errors++;
         end
      endfunction
   endclass

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   wire                  req_tready;
   logic [7:0]           req_tdata  = '0;
   logic                 req_tuser  = 1'b0;
   wire                  rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   wire  [23:0]          rsp_tdata;
   wire                  rsp_tuser;
   wire                  rsp_tlast;
   logic                 csr_valid  = 1'b0;
   wire                  csr_ready;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [CFG_W-1:0]     csr_data   = '0;

   logic                 steady     = 1'b0;
   int unsigned          quiet_cycles = 0;
   coin_path_tracker     tracker;

   grid_max_coin_path_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.check_beat(rsp_tdata, rsp_tuser, rsp_tlast);
      rsp_tready <= steady || ($urandom_range(99, 0) >= 37);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("grid_max_coin_path_unit_tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_cell(input logic blk, input logic [COINS_W-1:0] coins);
      if (!steady) begin
         while ($urandom_range(99, 0) < 37) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser  <= blk;
      req_tdata  <= {4'b0, coins};
      do @(posedge clock); while (!req_tready);
      tracker.note_cell(blk, coins);
   endtask

   task automatic run_cells(input int blk_pct, input int count);
      for (int i = 0; i < count; i++)
         send_cell(1'($urandom_range(99, 0) < blk_pct), COINS_W'($urandom_range(15, 0)));
   endtask

   // drop valid, drain the path beats, then let the unit settle before the next step
   task automatic settle();
      req_tvalid <= 1'b0;
      while (tracker.due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic post_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      tracker.take_reg(idx, val);
   endtask

   task automatic set_grid(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
      post_reg(CSR_NUM_ROWS, rows);
      post_reg(CSR_NUM_COLS, cols);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int sent, grid_no, rows, cols, pct, cells;
      tracker = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      set_grid(6'd0, 6'd0);
      send_cell(1'b0, 4'd15);
      settle();
      send_cell(1'b1, 4'd15);
      settle();
      send_cell(1'b0, 4'd0);
      settle();

      post_reg(CSR_SPARE_2, 6'h2a);
      post_reg(CSR_SPARE_3, 6'h15);
      csr_valid <= 1'b0;

      set_grid(6'd2, 6'd2);
      repeat (4) send_cell(1'b0, 4'd5);
      settle();
      send_cell(1'b0, 4'd0);
      send_cell(1'b0, 4'd9);
      send_cell(1'b0, 4'd0);
      send_cell(1'b0, 4'd0);
      settle();
      send_cell(1'b1, 4'd3);
      repeat (3) send_cell(1'b0, 4'd7);
      settle();

      set_grid(6'd1, 6'd3);
      send_cell(1'b0, 4'd4);
      send_cell(1'b1, 4'd4);
      send_cell(1'b0, 4'd4);
      settle();

      set_grid(6'd3, 6'd3);
      send_cell(1'b0, 4'd8);
      send_cell(1'b0, 4'd1);
      settle();
      set_grid(6'd3, 6'd2);
      run_cells(0, 6);
      settle();

      set_grid(6'd1, 6'd40);
      run_cells(0, 32);
      settle();
      set_grid(6'd63, 6'd1);
      run_cells(3, 32);
      settle();
      set_grid(6'd32, 6'd2);
      run_cells(4, 64);
      settle();

      sent = 0;
      grid_no = 0;
      while (sent < RANDOM_CELLS) begin
         rows = (grid_no % 12 == 11) ? $urandom_range(12, 1) : $urandom_range(6, 0);
         cols = (grid_no % 12 == 5) ? $urandom_range(12, 1) : $urandom_range(6, 0);
         case ($urandom_range(3, 0))
            0: pct = 0;
            1: pct = 5;
            2: pct = 15;
            default: pct = 40;
         endcase
         steady <= (sent >= 40 && sent < 120);
         cells = tracker.span(CFG_W'(rows)) * tracker.span(CFG_W'(cols));
         set_grid(CFG_W'(rows), CFG_W'(cols));
         if ($urandom_range(9, 0) == 0 && cells > 1) begin
            run_cells(pct, $urandom_range(cells - 1, 1));
            settle();
            set_grid(CFG_W'(rows), CFG_W'(cols));
         end
         run_cells(pct, cells);
         settle();
         sent += cells;
         grid_no++;
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.due.size() != 0) begin
         $error("%0d path beats never arrived", tracker.due.size());
         tracker.errors++;
      end
      if (tracker.errors == 0)
         $display("grid_max_coin_path_unit_tb: clean");
      else
         $display("grid_max_coin_path_unit_tb: errors");
      $finish;
   end

endmodule

/* files.f */
sv/gmcp_pkg.sv
sv/gmcp_ram.sv
sv/gmcp_dp.sv
sv/gmcp_ctrl.sv
sv/grid_max_coin_path_unit.sv
bench/grid_max_coin_path_unit_tb.sv
